FILE: sv/bis_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_pkg: shared types and constants of the image scaler
// Holds the item structs, register codes, controller states and the
// size clamp used by the scaler's controller and datapath.
// ----------------------------------------------------------------------------
package bis_pkg;

  localparam int MAX_PIXELS = 524288;
  localparam int MAX_DIM    = 1024;
  localparam int PIXEL_BITS = 16;

  // Configuration registers hold 11 bits, enough for MAX_DIM itself.
  localparam int DIM_W  = 11;
  localparam int ADDR_W = $clog2(MAX_PIXELS);
  // Positions in the source frame reach MAX_DIM * MAX_DIM.
  localparam int POS_W  = $clog2(MAX_DIM * MAX_DIM) + 1;

  localparam logic [DIM_W-1:0] RST_SRC_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_SRC_HEIGHT = DIM_W'(480);
  localparam logic [DIM_W-1:0] RST_DST_WIDTH  = DIM_W'(640);
  localparam logic [DIM_W-1:0] RST_DST_HEIGHT = DIM_W'(480);

  typedef enum logic [1:0] {
    REG_SRC_WIDTH,
    REG_SRC_HEIGHT,
    REG_DST_WIDTH,
    REG_DST_HEIGHT
  } cfg_reg_t;

  typedef enum logic {
    FUNC_LOAD,
    FUNC_EMIT
  } func_t;

  typedef struct packed {
    func_t                 func;
    logic [PIXEL_BITS-1:0] pixel_in;
  } in_item_t;

  typedef struct packed {
    logic [PIXEL_BITS-1:0] pixel_out;
    logic                  row_end;
    logic                  frame_end;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_DIV_X_START,
    ST_DIV_X_WAIT,
    ST_DIV_Y_START,
    ST_DIV_Y_WAIT,
    ST_MUL,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic div_start;
    logic div_y;
    logic cap_x;
    logic cap_y;
    logic mul_en;
    logic run;
  } ctrl_cmd_t;

  typedef struct packed {
    logic div_done;
  } dp_status_t;

  // A size of zero acts as one, sizes above MAX_DIM act as MAX_DIM.
  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: sv/bis_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_div: iterative divider for the scaling ratios
// Restoring division of two unsigned sizes, one quotient bit per cycle.
// Operands are latched on start; done pulses when the results are valid.
// ----------------------------------------------------------------------------
module bis_div (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  input  wire logic [bis_pkg::DIM_W-1:0] dividend,
  input  wire logic [bis_pkg::DIM_W-1:0] divisor,
  output logic                           done,
  output logic [bis_pkg::DIM_W-1:0]      quo,
  output logic [bis_pkg::DIM_W-1:0]      rem
);
  import bis_pkg::*;

  localparam int CNT_W = $clog2(DIM_W);

  logic [DIM_W:0]   rem_r, rem_nxt;
  logic [DIM_W-1:0] quo_r, quo_nxt;
  logic [DIM_W-1:0] den_r, den_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DIM_W:0]   trial;
  logic             fits;

  // The dividend shifts out of quo_r at the top while quotient bits enter below.
  assign trial = {rem_r[DIM_W-1:0], quo_r[DIM_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      den_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = fits ? (trial - {1'b0, den_r}) : trial;
      quo_nxt = {quo_r[DIM_W-2:0], fits};
      cnt_nxt = cnt_r + CNT_W'(1);
      if (cnt_r == CNT_W'(DIM_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r[DIM_W-1:0];

endmodule
`default_nettype wire

FILE: sv/bis_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_ctrl: sequencing controller of the image scaler
// Derives the column and row ratios after reset and after every register
// write, then lets the datapath stream load and emit requests.
// ----------------------------------------------------------------------------
module bis_ctrl (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire bis_pkg::dp_status_t    status,
  output bis_pkg::ctrl_cmd_t          cmd
);
  import bis_pkg::*;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    if (cfg_we) begin
      state_nxt = ST_DIV_X_START;
    end else begin
      unique case (state_r)
        ST_DIV_X_START: state_nxt = ST_DIV_X_WAIT;
        ST_DIV_X_WAIT:  if (status.div_done) state_nxt = ST_DIV_Y_START;
        ST_DIV_Y_START: state_nxt = ST_DIV_Y_WAIT;
        ST_DIV_Y_WAIT:  if (status.div_done) state_nxt = ST_MUL;
        ST_MUL:         state_nxt = ST_RUN;
        ST_RUN:         state_nxt = ST_RUN;
        default:        state_nxt = ST_DIV_X_START;
      endcase
    end
  end

  always_comb begin
    cmd = '0;
    unique case (state_r)
      ST_DIV_X_START: cmd.div_start = 1'b1;
      ST_DIV_X_WAIT:  cmd.cap_x     = status.div_done;
      ST_DIV_Y_START: begin
        cmd.div_start = 1'b1;
        cmd.div_y     = 1'b1;
      end
      ST_DIV_Y_WAIT:  cmd.cap_y     = status.div_done;
      ST_MUL:         cmd.mul_en    = 1'b1;
      ST_RUN:         cmd.run       = 1'b1;
      default:        cmd           = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_DIV_X_START;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Streaming may only begin once the row step and frame size are multiplied out.
  a_run_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> ($past(state_r) == ST_MUL || $past(state_r) == ST_RUN))
    else $error("scaler entered streaming without finishing the ratio setup");

endmodule
`default_nettype wire

FILE: sv/bis_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bis_datapath: registers, frame store and stepping logic of the scaler
// Holds the size registers and derived ratios, the load and emit positions
// with their Bresenham error terms, the frame store and the output stages.
// ----------------------------------------------------------------------------
module bis_datapath (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire bis_pkg::ctrl_cmd_t        cmd,
  output bis_pkg::dp_status_t            status,
  input  wire logic                      cfg_we,
  input  wire bis_pkg::cfg_reg_t         cfg_index,
  input  wire logic [bis_pkg::DIM_W-1:0] cfg_data,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bis_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bis_pkg::out_item_t             out_data
);
  import bis_pkg::*;

  // Size registers and their clamped values.
  logic [DIM_W-1:0] src_w_r, src_h_r, dst_w_r, dst_h_r;
  logic [DIM_W-1:0] sw_c, sh_c, dw_c, dh_c;

  // Derived ratios.
  logic [DIM_W-1:0] quo_x_r, rem_x_r, quo_y_r, rem_y_r;
  logic [POS_W-1:0] row_step_r, frame_px_r;
  logic [2*DIM_W-1:0] row_step_prod, frame_px_prod;

  logic             div_done;
  logic [DIM_W-1:0] div_quo, div_rem;

  // Load and emit positions.
  logic [POS_W-1:0] wr_pos_r, wr_pos_nxt;
  logic [POS_W-1:0] row_base_r, row_base_nxt;
  logic [DIM_W-1:0] row_err_r, row_err_nxt;
  logic [DIM_W-1:0] row_cnt_r, row_cnt_nxt;
  logic [DIM_W-1:0] col_pos_r, col_pos_nxt;
  logic [DIM_W-1:0] col_err_r, col_err_nxt;
  logic [DIM_W-1:0] col_cnt_r, col_cnt_nxt;

  // Stepping terms.
  logic [POS_W-1:0] wr_inc;
  logic             wr_wrap;
  logic [DIM_W-1:0] col_sum, row_sum, col_cnt_inc, row_cnt_inc;
  logic             col_carry, row_carry, step_row_end, step_frame_end;
  logic [POS_W-1:0] rd_addr;

  // Read stage and output register.
  logic [PIXEL_BITS-1:0] mem [MAX_PIXELS];
  logic [PIXEL_BITS-1:0] mem_q_r;
  logic                  rd_vld_r, rd_vld_nxt;
  logic                  rd_oob_r, rd_row_end_r, rd_frame_end_r;
  logic                  out_valid_r, out_valid_nxt;
  out_item_t             out_item_r;

  logic advance, in_acc, load_acc, emit_acc, mem_we;

  assign sw_c = clamp_dim(src_w_r);
  assign sh_c = clamp_dim(src_h_r);
  assign dw_c = clamp_dim(dst_w_r);
  assign dh_c = clamp_dim(dst_h_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_w_r <= RST_SRC_WIDTH;
      src_h_r <= RST_SRC_HEIGHT;
      dst_w_r <= RST_DST_WIDTH;
      dst_h_r <= RST_DST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SRC_WIDTH:  src_w_r <= cfg_data;
        REG_SRC_HEIGHT: src_h_r <= cfg_data;
        REG_DST_WIDTH:  dst_w_r <= cfg_data;
        REG_DST_HEIGHT: dst_h_r <= cfg_data;
        default:        src_w_r <= src_w_r;
      endcase
    end
  end

  bis_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (cmd.div_y ? sh_c : sw_c),
    .divisor  (cmd.div_y ? dh_c : dw_c),
    .done     (div_done),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  assign status.div_done = div_done;

  assign row_step_prod = quo_y_r * sw_c;
  assign frame_px_prod = sw_c * sh_c;

  always_ff @(posedge clk) begin
    if (cmd.cap_x) begin
      quo_x_r <= div_quo;
      rem_x_r <= div_rem;
    end
    if (cmd.cap_y) begin
      quo_y_r <= div_quo;
      rem_y_r <= div_rem;
    end
    if (cmd.mul_en) begin
      row_step_r <= row_step_prod[POS_W-1:0];
      frame_px_r <= frame_px_prod[POS_W-1:0];
    end
  end

  // Handshake: an emit result that cannot move on holds the read stage.
  assign advance  = !out_valid_r || !out_stall;
  assign in_stall = !cmd.run || (rd_vld_r && !advance);
  assign in_acc   = in_valid && !in_stall;
  assign load_acc = in_acc && (in_data.func == FUNC_LOAD);
  assign emit_acc = in_acc && (in_data.func == FUNC_EMIT);

  assign wr_inc  = wr_pos_r + POS_W'(1);
  assign wr_wrap = wr_inc >= frame_px_r;
  assign mem_we  = load_acc && (wr_pos_r[POS_W-1:ADDR_W] == '0);

  assign col_sum        = col_err_r + rem_x_r;
  assign col_carry      = col_sum >= dw_c;
  assign col_cnt_inc    = col_cnt_r + DIM_W'(1);
  assign step_row_end   = col_cnt_inc >= dw_c;
  assign row_sum        = row_err_r + rem_y_r;
  assign row_carry      = row_sum >= dh_c;
  assign row_cnt_inc    = row_cnt_r + DIM_W'(1);
  assign step_frame_end = step_row_end && (row_cnt_inc >= dh_c);
  assign rd_addr        = row_base_r + POS_W'(col_pos_r);

  always_comb begin
    wr_pos_nxt   = wr_pos_r;
    row_base_nxt = row_base_r;
    row_err_nxt  = row_err_r;
    row_cnt_nxt  = row_cnt_r;
    col_pos_nxt  = col_pos_r;
    col_err_nxt  = col_err_r;
    col_cnt_nxt  = col_cnt_r;
    priority if (cfg_we || (load_acc && wr_wrap)) begin
      // A register write or the end of a source frame restarts both sides.
      wr_pos_nxt   = '0;
      row_base_nxt = '0;
      row_err_nxt  = '0;
      row_cnt_nxt  = '0;
      col_pos_nxt  = '0;
      col_err_nxt  = '0;
      col_cnt_nxt  = '0;
    end else if (load_acc) begin
      wr_pos_nxt = wr_inc;
    end else if (emit_acc) begin
      if (!step_row_end) begin
        col_pos_nxt = col_pos_r + quo_x_r + DIM_W'(col_carry);
        col_err_nxt = col_carry ? (col_sum - dw_c) : col_sum;
        col_cnt_nxt = col_cnt_inc;
      end else begin
        col_pos_nxt = '0;
        col_err_nxt = '0;
        col_cnt_nxt = '0;
        if (step_frame_end) begin
          row_base_nxt = '0;
          row_err_nxt  = '0;
          row_cnt_nxt  = '0;
        end else begin
          row_base_nxt = row_base_r + row_step_r + (row_carry ? POS_W'(sw_c) : '0);
          row_err_nxt  = row_carry ? (row_sum - dh_c) : row_sum;
          row_cnt_nxt  = row_cnt_inc;
        end
      end
    end else begin
      wr_pos_nxt = wr_pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_pos_r   <= '0;
      row_base_r <= '0;
      row_err_r  <= '0;
      row_cnt_r  <= '0;
      col_pos_r  <= '0;
      col_err_r  <= '0;
      col_cnt_r  <= '0;
    end else begin
      wr_pos_r   <= wr_pos_nxt;
      row_base_r <= row_base_nxt;
      row_err_r  <= row_err_nxt;
      row_cnt_r  <= row_cnt_nxt;
      col_pos_r  <= col_pos_nxt;
      col_err_r  <= col_err_nxt;
      col_cnt_r  <= col_cnt_nxt;
    end
  end

  // Frame store.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_pos_r[ADDR_W-1:0]] <= in_data.pixel_in;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      mem_q_r <= mem[rd_addr[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (emit_acc) begin
      rd_oob_r       <= rd_addr[POS_W-1:ADDR_W] != '0;
      rd_row_end_r   <= step_row_end;
      rd_frame_end_r <= step_frame_end;
    end
  end

  always_comb begin
    rd_vld_nxt    = rd_vld_r;
    out_valid_nxt = out_valid_r;
    if (advance) begin
      out_valid_nxt = rd_vld_r;
      rd_vld_nxt    = 1'b0;
    end
    if (emit_acc) begin
      rd_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && rd_vld_r) begin
      out_item_r.pixel_out <= rd_oob_r ? '0 : mem_q_r;
      out_item_r.row_end   <= rd_row_end_r;
      out_item_r.frame_end <= rd_frame_end_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

  // A read waiting behind a stalled result must not be dropped or overwritten.
  a_rd_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_vld_r && !advance) |=> (rd_vld_r && $stable(mem_q_r)))
    else $error("pending frame store read lost while output stalled");

  a_col_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> (col_err_r < dw_c && col_cnt_r < dw_c))
    else $error("column error term or count out of range");

  a_row_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.run |-> (row_err_r < dh_c && row_cnt_r < dh_c))
    else $error("row error term or count out of range");

endmodule
`default_nettype wire

FILE: sv/bresenham_image_scaler.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bresenham_image_scaler: nearest-neighbor frame scaler
// Source pixels are loaded in raster order into a frame store; destination
// pixels are read back in raster order with Bresenham column/row stepping.
// ----------------------------------------------------------------------------
// Usage:
// Each request on the in_ channel is either a load (pixel_in goes to the next
// source position) or an emit (one result on the out_ channel). Requests are
// taken at one per cycle while in_stall is low; a load gives no result.
// An emit's result is read from the store into a register when the emit is
// taken, and moves on into the output register once that can advance.
// While the receiver stalls, one more emit may enter and wait in the read
// stage; after that in_stall rises until the result is taken.
// Registers are written on the cfg_ channel (cfg_ready is always high). After
// reset and after each write the column and row ratios are derived by a
// shared bit-serial divider and one multiply step; in_stall stays high while
// this runs. A write also restarts load and emit positions at the top of the
// frame. The frame store is not cleared: emits should only address pixels
// that were loaded.
// ----------------------------------------------------------------------------
module bresenham_image_scaler (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  output logic                           in_stall,
  input  wire bis_pkg::in_item_t         in_data,
  output logic                           out_valid,
  input  wire logic                      out_stall,
  output bis_pkg::out_item_t             out_data,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire bis_pkg::cfg_reg_t         cfg_index,
  input  wire logic [bis_pkg::DIM_W-1:0] cfg_data
);
  import bis_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;
  logic       cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;

  bis_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_we (cfg_we),
    .status (status),
    .cmd    (cmd)
  );

  bis_datapath u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
